// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/fcrc_pkg.sv
// ----------------------------------------------------------------------------
// fcrc_pkg
// Constants, types and the byte-wise CRC step for the frame CRC block.
// ----------------------------------------------------------------------------
package fcrc_pkg;

	localparam int PAYLOAD_BYTES_DEF = 22;
	localparam int POS_W             = 5;
	localparam int CRC_W             = 16;
	localparam int CFG_IDX_W         = 1;
	localparam int FIFO_DEPTH        = 4;
	localparam int PTR_W             = 2;
	localparam int CNT_W             = 3;

	localparam logic [CRC_W-1:0] CRC_INIT     = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY_RST = 16'hA001;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 1'd1;

	typedef struct packed {
		logic       last;
		logic       crc_ok;
		logic [7:0] out_byte;
	} result_t;

	// One reflected CRC byte step; the table entry is built bit by bit from poly.
	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
	                                              input logic [7:0] b,
	                                              input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] v;
		v = {8'h00, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
		end
		return (crc >> 8) ^ v;
	endfunction

endpackage

// File: src/frame_crc16_append_check.sv
// ----------------------------------------------------------------------------
// frame_crc16_append_check
// Streaming CRC-16/MODBUS over fixed-length frames: append or verify.
// ----------------------------------------------------------------------------
// Usage:
//   Feed frame bytes on the s_ side, one per transfer, with s_tuser set on the
//   first byte of a frame. Every byte is echoed on the m_ side. The first
//   PAYLOAD_BYTES bytes of a frame run through the CRC. In generate mode the
//   last payload byte is followed by the CRC high and low bytes, the low byte
//   flagged with m_tlast. In check mode the two bytes after the payload are the
//   stored CRC (high first); the echo of the second carries m_tlast and m_tuser
//   set when it matches. A frame restarts by itself once it is complete.
//   Configuration: cfg_we with cfg_idx 0 writes check_mode, 1 writes crc_poly;
//   write only while the block is idle.
// Data path and throughput:
//   A transfer lands in the input stage, moves into a four-entry output queue
//   once three of its slots are free, and is then shown on m_ from its head.
//   One byte per cycle sustained while m_tready stays high; the CRC burst
//   at the end of a generate-mode frame adds two output bytes, absorbed by
//   the queue and by holding s_tready low while fewer than three slots are free.
// Reset and stall:
//   arst_n clears the queue, the input stage and the frame state; the CRC
//   returns to 0xFFFF. When m_tready is low the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_crc16_append_check #(
	parameter int PAYLOAD_BYTES = fcrc_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [fcrc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fcrc_pkg::CRC_W-1:0]     cfg_wdata,
	// input byte stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic                           s_tuser,   // [0] frame_start
	// output byte stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic                           m_tuser,   // [0] crc_ok
	output logic                           m_tlast
);

	localparam logic [fcrc_pkg::POS_W-1:0] POS_PAY  = fcrc_pkg::POS_W'(PAYLOAD_BYTES);
	localparam logic [fcrc_pkg::POS_W-1:0] POS_CHK  = fcrc_pkg::POS_W'(PAYLOAD_BYTES + 1);
	localparam logic [fcrc_pkg::POS_W-1:0] POS_FULL = fcrc_pkg::POS_W'(PAYLOAD_BYTES + 2);
	localparam int FIFO_DEPTH_L = fcrc_pkg::FIFO_DEPTH;

	// configuration
	logic                       check_q;
	logic [fcrc_pkg::CRC_W-1:0] poly_q;

	// frame state
	logic [fcrc_pkg::CRC_W-1:0] crc_q;
	logic [fcrc_pkg::POS_W-1:0] pos_q;
	logic [7:0]                 stored_hi_q;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// output queue
	fcrc_pkg::result_t          fifo_q [FIFO_DEPTH_L];
	logic [fcrc_pkg::PTR_W-1:0] rd_ptr_q;
	logic [fcrc_pkg::PTR_W-1:0] wr_ptr_q;
	logic [fcrc_pkg::CNT_W-1:0] cnt_q;

	// processing
	logic                       can_proc;
	logic                       fire;
	logic                       pop;
	logic [fcrc_pkg::POS_W-1:0] frame_len;
	logic                       restart;
	logic [fcrc_pkg::CRC_W-1:0] crc_base;
	logic [fcrc_pkg::POS_W-1:0] pos_base;
	logic [fcrc_pkg::CRC_W-1:0] crc_new;
	logic [fcrc_pkg::POS_W-1:0] pos_inc;
	logic [fcrc_pkg::CRC_W-1:0] crc_nxt;
	logic [fcrc_pkg::POS_W-1:0] pos_nxt;
	logic                       hi_we;
	logic [1:0]                 push_cnt;
	fcrc_pkg::result_t          push_res [FIFO_DEPTH_L];
	logic [fcrc_pkg::PTR_W-1:0] wr_off [FIFO_DEPTH_L];

	// Process the staged byte only when three queue slots are free.
	assign can_proc = (cnt_q <= fcrc_pkg::CNT_W'(FIFO_DEPTH_L - 3));
	assign fire     = valid_s1 && can_proc;
	assign s_tready = !valid_s1 || can_proc;
	assign pop      = m_tvalid && m_tready;

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = fifo_q[rd_ptr_q].out_byte;
	assign m_tuser  = fifo_q[rd_ptr_q].crc_ok;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	// Frame step: restart, CRC update, and results for one byte.
	always_comb begin
		frame_len = check_q ? POS_FULL : POS_PAY;
		restart   = start_s1 || (pos_q >= frame_len);
		crc_base  = restart ? fcrc_pkg::CRC_INIT : crc_q;
		pos_base  = restart ? '0 : pos_q;
		crc_new   = fcrc_pkg::crc_step(crc_base, data_s1, poly_q);
		pos_inc   = pos_base + 1'b1;
		hi_we     = 1'b0;
		push_cnt  = 2'd1;
		for (int i = 0; i < FIFO_DEPTH_L; i++) begin
			push_res[i] = '0;
		end
		push_res[0].out_byte = data_s1;
		if (pos_base < POS_PAY) begin
			if (!check_q && (pos_inc == POS_PAY)) begin
				// last payload byte in generate mode: append CRC, high byte first
				push_cnt             = 2'd3;
				push_res[1].out_byte = crc_new[15:8];
				push_res[2].out_byte = crc_new[7:0];
				push_res[2].last     = 1'b1;
				crc_nxt              = fcrc_pkg::CRC_INIT;
				pos_nxt              = '0;
			end else begin
				crc_nxt = crc_new;
				pos_nxt = pos_inc;
			end
		end else if (pos_base == POS_PAY) begin
			// stored CRC high byte
			hi_we   = 1'b1;
			crc_nxt = crc_base;
			pos_nxt = POS_CHK;
		end else begin
			// stored CRC low byte: compare and close the frame
			push_res[0].crc_ok = ({stored_hi_q, data_s1} == crc_base);
			push_res[0].last   = 1'b1;
			crc_nxt            = fcrc_pkg::CRC_INIT;
			pos_nxt            = '0;
		end
		for (int i = 0; i < FIFO_DEPTH_L; i++) begin
			wr_off[i] = fcrc_pkg::PTR_W'(i) - wr_ptr_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= 1'b0;
			poly_q  <= fcrc_pkg::CRC_POLY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fcrc_pkg::REG_CHECK_MODE: check_q <= cfg_wdata[0];
				fcrc_pkg::REG_CRC_POLY:   poly_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage: take a transfer whenever the stage is empty or advancing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// Frame state: advance on every processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= fcrc_pkg::CRC_INIT;
			pos_q       <= '0;
			stored_hi_q <= '0;
		end else if (fire) begin
			crc_q <= crc_nxt;
			pos_q <= pos_nxt;
			if (hi_we) begin
				stored_hi_q <= data_s1;
			end
		end
	end

	// Output queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + fcrc_pkg::PTR_W'(push_cnt);
			end
			cnt_q <= cnt_q + (fire ? fcrc_pkg::CNT_W'(push_cnt) : '0)
			         - fcrc_pkg::CNT_W'(pop);
		end
	end

	// Output queue storage: up to three entries written per processed byte.
	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH_L; i++) begin
			if (fire && (wr_off[i] < fcrc_pkg::PTR_W'(push_cnt))) begin
				fifo_q[i] <= push_res[wr_off[i]];
			end
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= fcrc_pkg::CNT_W'(FIFO_DEPTH_L))
	`ASSERT_ALWAYS(a_pos_range, pos_q <= POS_CHK)
	`ASSERT_NEXT(a_stall_hold, valid_s1 && !can_proc, valid_s1 && $stable(data_s1))
	`ASSERT_NEXT(a_frame_close, fire && (push_cnt == 2'd3 || push_res[0].last),
		pos_q == '0 && crc_q == fcrc_pkg::CRC_INIT)

endmodule

// File: sim/fcrc_checker.sv
// ----------------------------------------------------------------------------
// fcrc_checker
// Watches the configuration port and both byte streams of the frame CRC
// block, predicts every output transfer from the accepted input bytes and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
package fcrc_tb_pkg;

	// Bit-serial reflected CRC step over one byte; same result as the table form.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
	                                           input logic [15:0] poly);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ poly;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

endpackage

module fcrc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fcrc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [fcrc_pkg::CRC_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic                           s_tuser,   // [0] frame_start
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,   // [7:0] out_byte
	input  logic                           m_tuser,   // [0] crc_ok
	input  logic                           m_tlast,
	output int                             n_pending,
	output int                             n_errors
);

	localparam int FRAME_PAYLOAD = fcrc_pkg::PAYLOAD_BYTES_DEF;
	localparam int MAX_REPORTS   = 10;

	logic              chk_mode;
	logic [15:0]       poly;
	logic [15:0]       crc;
	logic [4:0]        pos;
	logic [7:0]        crc_hi;
	fcrc_pkg::result_t tx_q[$];

	task automatic push_tx(input logic [7:0] ob, input logic ok, input logic lst);
		fcrc_pkg::result_t r;
		r.out_byte = ob;
		r.crc_ok   = ok;
		r.last     = lst;
		tx_q.push_back(r);
	endtask

	task automatic restart_frame();
		crc = fcrc_pkg::CRC_INIT;
		pos = '0;
	endtask

	// Advance the frame state by one input byte and queue the transfers it causes.
	task automatic step_frame(input logic [7:0] b, input logic sof);
		int frame_len;
		frame_len = chk_mode ? FRAME_PAYLOAD + 2 : FRAME_PAYLOAD;
		if (sof || int'(pos) >= frame_len) begin
			restart_frame();
		end
		if (int'(pos) < FRAME_PAYLOAD) begin
			crc = fcrc_tb_pkg::crc16_byte(crc, b, poly);
			pos = pos + 5'd1;
			push_tx(b, 1'b0, 1'b0);
			if (!chk_mode && int'(pos) == FRAME_PAYLOAD) begin
				push_tx(crc[15:8], 1'b0, 1'b0);
				push_tx(crc[7:0], 1'b0, 1'b1);
				restart_frame();
			end
		end else if (int'(pos) == FRAME_PAYLOAD) begin
			crc_hi = b;
			pos    = pos + 5'd1;
			push_tx(b, 1'b0, 1'b0);
		end else begin
			push_tx(b, {crc_hi, b} == crc, 1'b1);
			restart_frame();
		end
	endtask

	task automatic check_tx();
		fcrc_pkg::result_t want;
		if (tx_q.size() == 0) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS) begin
				$display("unexpected transfer: out_byte %02h crc_ok %0b last %0b",
				         m_tdata, m_tuser, m_tlast);
			end
		end else begin
			want = tx_q.pop_front();
			if (m_tdata !== want.out_byte || m_tuser !== want.crc_ok
			    || m_tlast !== want.last) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS) begin
					$display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b (byte/ok/last)",
					         want.out_byte, want.crc_ok, want.last,
					         m_tdata, m_tuser, m_tlast);
				end
			end
		end
	endtask

	// Outgoing transfers belong to older input, so compare before predicting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_mode  = 1'b0;
			poly      = fcrc_pkg::CRC_POLY_RST;
			crc_hi    = '0;
			restart_frame();
			tx_q.delete();
			n_pending = 0;
			n_errors  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_tx();
			end
			if (cfg_we) begin
				case (cfg_idx)
					fcrc_pkg::REG_CHECK_MODE: chk_mode = cfg_wdata[0];
					fcrc_pkg::REG_CRC_POLY:   poly = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				step_frame(s_tdata, s_tuser);
			end
			n_pending = tx_q.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for frame_crc16_append_check: a directed frame, frames
// with register writes landing mid-frame, then random frames under changing
// mode and polynomial settings, with random gaps on both streams. The checker
// beside the block predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int PAYLOAD     = fcrc_pkg::PAYLOAD_BYTES_DEF;
	localparam int ITEMS       = 250;        // minimum number of input bytes to send
	localparam int TAIL_ITEMS  = 40;         // final stretch without idling
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 20;         // extra wait after the drain, before the verdict

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [fcrc_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [fcrc_pkg::CRC_W-1:0]     cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [7:0]                     s_tdata;   // [7:0] data_byte
	logic                           s_tuser;   // [0] frame_start
	logic                           m_tvalid;
	logic                           m_tready;
	logic [7:0]                     m_tdata;   // [7:0] out_byte
	logic                           m_tuser;   // [0] crc_ok
	logic                           m_tlast;

	int                             n_pending;
	int                             n_errors;

	// Stimulus-side copy of the settings, used to build frames with a valid CRC
	logic                           cur_mode;
	logic [15:0]                    cur_poly;
	logic                           idle_on;
	int                             items_sent;

	frame_crc16_append_check i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	fcrc_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.n_pending (n_pending),
		.n_errors  (n_errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bias toward all-zero and all-one bytes, otherwise uniform.
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 5) == 0) begin
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return 8'($urandom);
	endfunction

	// Offer one byte at the falling edge and hold it until the block takes it.
	// Valid stays high on return so back-to-back transfers need no toggle.
	task automatic put_byte(input logic [7:0] b, input logic sof);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = sof;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
		if (items_sent >= ITEMS - TAIL_ITEMS) begin
			idle_on = 1'b0;
		end
	endtask

	// Drop valid and hold off until every predicted transfer has come out.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (n_pending != 0) @(negedge clk);
	endtask

	// Write one register for one cycle; call only with the block drained.
	task automatic write_reg(input logic [fcrc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == fcrc_pkg::REG_CHECK_MODE) begin
			cur_mode = val[0];
		end else begin
			cur_poly = val;
		end
	endtask

	// Send n_payload payload bytes; a full payload in check mode is followed by
	// the stored CRC, high byte first, with one bit flipped when bad_crc is set.
	task automatic send_frame(input int n_payload, input logic sof, input logic bad_crc);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = fcrc_pkg::CRC_INIT;
		for (int i = 0; i < n_payload; i++) begin
			b   = pick_byte();
			crc = fcrc_tb_pkg::crc16_byte(crc, b, cur_poly);
			put_byte(b, sof && i == 0);
		end
		if (cur_mode && n_payload == PAYLOAD) begin
			if (bad_crc) begin
				crc ^= 16'd1 << $urandom_range(0, 15);
			end
			put_byte(crc[15:8], 1'b0);
			put_byte(crc[7:0], 1'b0);
		end
	endtask

	// Ready side: random stall bursts while idling is on, otherwise always ready.
	initial begin : rx_side
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				m_tready = 1'b0;
				n = $urandom_range(1, 13);
			end else begin
				m_tready = 1'b1;
				n = $urandom_range(1, 20);
			end
			repeat (n) @(negedge clk);
		end
	end

	// Cycle budget; a hang anywhere ends here.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  b;
		logic        aligned;
		logic        nxt_mode;
		logic [15:0] nxt_poly;
		int          ph;
		int          r;
		int          n;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = fcrc_pkg::REG_CHECK_MODE;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		cur_mode   = 1'b0;
		cur_poly   = fcrc_pkg::CRC_POLY_RST;
		idle_on    = 1'b1;
		items_sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frame under reset settings: corner bytes first, then random
		for (int i = 0; i < PAYLOAD; i++) begin
			case (i)
				0: b = 8'h00;
				1: b = 8'hFF;
				2: b = 8'h01;
				3: b = 8'h80;
				4: b = 8'h7F;
				5: b = 8'hFE;
				6: b = 8'h55;
				7: b = 8'hAA;
				default: b = pick_byte();
			endcase
			put_byte(b, i == 0);
		end

		// Polynomial swapped after ten payload bytes of a generate-mode frame
		send_frame(10, 1'b1, 1'b0);
		wait_drained();
		write_reg(fcrc_pkg::REG_CRC_POLY, 16'h8408);
		send_frame(PAYLOAD - 10, 1'b0, 1'b0);

		// Check mode stopped right after the stored high byte, then generate
		// mode picks up: the leftover position must restart the frame
		wait_drained();
		write_reg(fcrc_pkg::REG_CHECK_MODE, {15'($urandom), 1'b1});
		send_frame(PAYLOAD - 1, 1'b1, 1'b0);
		put_byte(pick_byte(), 1'b0);
		put_byte(pick_byte(), 1'b0);
		wait_drained();
		write_reg(fcrc_pkg::REG_CHECK_MODE, {15'($urandom), 1'b0});
		send_frame(PAYLOAD, 1'b0, 1'b0);

		// Generate-mode frame turned into a check-mode frame partway
		send_frame(5, 1'b1, 1'b0);
		wait_drained();
		write_reg(fcrc_pkg::REG_CHECK_MODE, {15'($urandom), 1'b1});
		send_frame(PAYLOAD - 5, 1'b0, 1'b0);
		put_byte(pick_byte(), 1'b0);
		put_byte(pick_byte(), 1'b0);

		// Random frames; settings change between phases, extremes first.
		// Most frames are whole with a matching CRC; some are cut short or
		// carry a corrupted CRC.
		aligned    = 1'b1;
		ph         = 0;
		while (items_sent < ITEMS) begin
			case (ph)
				0: begin nxt_mode = 1'b1; nxt_poly = fcrc_pkg::CRC_POLY_RST; end
				1: begin nxt_mode = 1'b0; nxt_poly = 16'h0000; end
				2: begin nxt_mode = 1'b1; nxt_poly = 16'hFFFF; end
				3: begin nxt_mode = 1'b0; nxt_poly = 16'hFFFF; end
				4: begin nxt_mode = 1'b1; nxt_poly = 16'h0000; end
				default: begin
					nxt_mode = 1'($urandom_range(0, 1));
					nxt_poly = $urandom_range(0, 1) ? fcrc_pkg::CRC_POLY_RST
					                                : 16'($urandom);
				end
			endcase
			wait_drained();
			write_reg(fcrc_pkg::REG_CHECK_MODE, {15'($urandom), nxt_mode});
			write_reg(fcrc_pkg::REG_CRC_POLY, nxt_poly);
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(0, 9);
				n = (r == 0) ? $urandom_range(1, PAYLOAD - 1) : PAYLOAD;
				// a cut-short frame leaves the block mid-frame: force a restart
				send_frame(n, !aligned || $urandom_range(0, 1), r == 1 || r == 2);
				aligned = (n == PAYLOAD);
			end
			ph++;
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_errors == 0 && n_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
